[src/saq_pkg.sv]
// Package for the sensor alarm qualifier: codes, constants and the
// configuration register index. No dependencies.
`default_nettype none
package saq_pkg;
  localparam int SENSOR_SLOTS_DEF  = 16;
  localparam int HISTORY_DEPTH_DEF = 32;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_RAISED  = 3'd1;
  localparam logic [2:0] ST_CLEARED = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_BAD_IDX = 3'd4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_HIGH = 2'd1;
  localparam logic [1:0] KIND_LOW  = 2'd2;

  localparam logic [1:0] PH_NORMAL    = 2'd0;
  localparam logic [1:0] PH_PENDING   = 2'd1;
  localparam logic [1:0] PH_TRIGGERED = 2'd2;

  localparam logic [1:0] REG_HIGH = 2'd0;
  localparam logic [1:0] REG_LOW  = 2'd1;
  localparam logic [1:0] REG_RUN  = 2'd2;

  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_TSCAN, S_TRD, S_TUPD, S_LSCAN, S_LRD, S_LADD,
    S_RSCAN, S_RRD, S_HRD, S_HOUT, S_DONE
  } state_t;
endpackage
`default_nettype wire

[src/saq_if.sv]
// Channel interfaces for the sensor alarm qualifier: input item, result item
// and configuration write. No dependencies.
`default_nettype none
interface saq_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [15:0] sensor_key;
  logic is_temperature;
  logic signed [15:0] temperature;
  logic [31:0] timestamp;
  logic [4:0] history_index;
  modport source (output valid, cmd, sensor_key, is_temperature, temperature,
                  timestamp, history_index, input ready);
  modport sink (input valid, cmd, sensor_key, is_temperature, temperature,
                timestamp, history_index, output ready);
endinterface

interface saq_out_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [15:0] rec_sensor_key;
  logic [1:0] rec_kind;
  logic signed [15:0] rec_temperature;
  logic [31:0] rec_start_time;
  logic [31:0] rec_end_time;
  logic rec_active;
  logic [5:0] history_fill;
  modport source (output valid, status, rec_sensor_key, rec_kind, rec_temperature,
                  rec_start_time, rec_end_time, rec_active, history_fill,
                  input ready);
  modport sink (input valid, status, rec_sensor_key, rec_kind, rec_temperature,
                rec_start_time, rec_end_time, rec_active, history_fill,
                output ready);
endinterface

interface saq_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/sensor_alarm_qualifier_log.sv]
// Top level of the sensor alarm qualifier with alarm history ring.
// Depends on saq_pkg and the channel interfaces in saq_if.sv.
`default_nettype none
// One item at a time. A check scans the tracker table slot by slot, one
// state to read and one to compare. A trigger then scans the log the same
// way for an active duplicate, and a clear scans it resolving records. A
// read checks the index and, if it is valid, reads the log once before its
// result. The scans through the tracker and log memories, one read port
// each, set the time from acceptance to result. The result sits in an
// output register; ready returns after it is taken. No clearing pass after
// reset.
module sensor_alarm_qualifier_log #(
  parameter int SENSOR_SLOTS  = saq_pkg::SENSOR_SLOTS_DEF,
  parameter int HISTORY_DEPTH = saq_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  saq_in_if.sink    in_ch,
  saq_out_if.source out_ch,
  saq_cfg_if.sink   cfg
);
  import saq_pkg::*;

  localparam int TW = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;
  localparam int TC = $clog2(SENSOR_SLOTS + 1);
  localparam int LW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int LC = $clog2(HISTORY_DEPTH + 1);

  // Tracker entry: key, phase, kind, run, first time
  localparam int TRW = 16 + 2 + 2 + 8 + 32;
  // Log entry: key, kind, temp, start, end, active
  localparam int LRW = 16 + 2 + 16 + 32 + 32 + 1;

  logic [TRW-1:0] trk_mem [SENSOR_SLOTS];
  logic [LRW-1:0] log_mem [HISTORY_DEPTH];
  logic [TRW-1:0] trk_rd;
  logic [LRW-1:0] log_rd;

  logic signed [15:0] high_threshold, low_threshold;
  logic [7:0] run_needed;
  logic [TC-1:0] trk_used;
  logic [LC-1:0] log_used;
  logic [LW-1:0] log_oldest;

  state_t state, state_next;

  // latched item
  logic [15:0] key;
  logic signed [15:0] temp;
  logic [31:0] ts;
  logic [4:0] hidx;

  logic [TC-1:0] tcnt;
  logic [LC-1:0] lcnt;
  logic [TW-1:0] tslot;
  logic [LW-1:0] lslot;
  logic tfound;
  logic [TRW-1:0] trk_cur;

  // control from sequencer
  logic trk_we, log_we, tr_rd_en, lg_rd_en, done_set;
  logic [TW-1:0] trk_waddr, trk_raddr;
  logic [LW-1:0] log_waddr, log_raddr;
  logic [TRW-1:0] trk_wdata;
  logic [LRW-1:0] log_wdata;
  logic [2:0] st_next;

  // output register
  logic out_valid;
  logic [2:0] o_status;
  logic [LRW-1:0] o_rec;

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign cfg.ready   = 1'b1;
  wire in_acc = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold <= 16'sd480;
      low_threshold  <= 16'sd0;
      run_needed     <= 8'd3;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HIGH: high_threshold <= cfg.data;
        REG_LOW:  low_threshold  <= cfg.data;
        REG_RUN:  run_needed     <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (trk_we) trk_mem[trk_waddr] <= trk_wdata;
    if (tr_rd_en) trk_rd <= trk_mem[trk_raddr];
  end
  always_ff @(posedge clk) begin
    if (log_we) log_mem[log_waddr] <= log_wdata;
    if (lg_rd_en) log_rd <= log_mem[log_raddr];
  end

  // classification of the reading
  logic [1:0] rkind;
  always_comb begin
    priority if (temp > high_threshold) rkind = KIND_HIGH;
    else if (temp < low_threshold) rkind = KIND_LOW;
    else rkind = KIND_NONE;
  end

  // fields of the tracker entry read back
  wire [15:0] t_key   = trk_rd[TRW-1 -: 16];
  wire [1:0]  c_phase = trk_cur[43:42];
  wire [1:0]  c_kind  = trk_cur[41:40];
  wire [7:0]  c_run   = trk_cur[39:32];
  wire [31:0] c_first = trk_cur[31:0];
  wire [7:0]  run_inc = (c_run == 8'hFF) ? c_run : c_run + 8'd1;

  wire [15:0] l_key    = log_rd[LRW-1 -: 16];
  wire        l_active = log_rd[0];
  wire [LC-1:0] hidx_w = LC'(hidx);
  wire [LC:0] hsum = (LC+1)'(log_oldest) + (LC+1)'(hidx);
  wire [LW-1:0] hslot = (log_used == LC'(HISTORY_DEPTH)) ?
      ((hsum >= (LC+1)'(HISTORY_DEPTH)) ? LW'(hsum - (LC+1)'(HISTORY_DEPTH)) : LW'(hsum))
      : LW'(hidx);
  wire trig_now = (run_inc >= run_needed);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    trk_we = 1'b0; log_we = 1'b0; tr_rd_en = 1'b0; lg_rd_en = 1'b0;
    done_set = 1'b0; st_next = ST_NONE;
    trk_waddr = tslot; trk_raddr = TW'(tcnt);
    log_waddr = lslot; log_raddr = LW'(lcnt);
    trk_wdata = trk_cur; log_wdata = log_rd;
    unique case (state)
      S_IDLE: if (in_acc) begin
        if (in_ch.cmd == CMD_READ) state_next = S_HRD;
        else if (!in_ch.is_temperature) begin
          done_set = 1'b1; state_next = S_IDLE;
        end else state_next = S_TSCAN;
      end
      S_TSCAN: begin
        if (tfound || tcnt >= trk_used) begin
          if (!tfound && trk_used == TC'(SENSOR_SLOTS)) begin
            st_next = ST_FULL; done_set = 1'b1; state_next = S_IDLE;
          end else state_next = S_TUPD;
        end else begin
          tr_rd_en = 1'b1; state_next = S_TRD;
        end
      end
      S_TRD: state_next = S_TSCAN;
      S_TUPD: begin
        trk_we = 1'b1;
        if (rkind != KIND_NONE) begin
          if (c_phase == PH_NORMAL || (c_phase == PH_PENDING && c_kind != rkind)) begin
            trk_wdata = {key, PH_PENDING, rkind, 8'd1, ts};
            done_set = 1'b1; state_next = S_IDLE;
          end else if (c_phase == PH_PENDING) begin
            if (trig_now) begin
              trk_wdata = {key, PH_TRIGGERED, c_kind, run_inc, c_first};
              state_next = S_LSCAN;
            end else begin
              trk_wdata = {key, PH_PENDING, c_kind, run_inc, c_first};
              done_set = 1'b1; state_next = S_IDLE;
            end
          end else begin
            done_set = 1'b1; state_next = S_IDLE;
          end
        end else begin
          trk_wdata = {key, PH_NORMAL, KIND_NONE, 8'd0, c_first};
          if (c_phase == PH_TRIGGERED) state_next = S_RSCAN;
          else begin
            done_set = 1'b1; state_next = S_IDLE;
          end
        end
      end
      S_LSCAN: begin
        if (lcnt >= log_used) state_next = S_LADD;
        else begin
          lg_rd_en = 1'b1; state_next = S_LRD;
        end
      end
      S_LRD: begin
        if (l_active && l_key == key) begin
          done_set = 1'b1; state_next = S_IDLE;
        end else state_next = S_LSCAN;
      end
      S_LADD: begin
        log_we = 1'b1;
        log_waddr = (log_used < LC'(HISTORY_DEPTH)) ? LW'(log_used) : log_oldest;
        log_wdata = {key, c_kind, temp, c_first, 32'd0, 1'b1};
        st_next = ST_RAISED; done_set = 1'b1; state_next = S_IDLE;
      end
      S_RSCAN: begin
        if (lcnt >= log_used) begin
          st_next = ST_CLEARED; done_set = 1'b1; state_next = S_IDLE;
        end else begin
          lg_rd_en = 1'b1; state_next = S_RRD;
        end
      end
      S_RRD: begin
        // keep key, kind, temperature and start; stamp the end and drop active
        if (l_active && l_key == key) begin
          log_we = 1'b1;
          log_wdata = {log_rd[LRW-1:33], ts, 1'b0};
        end
        state_next = S_RSCAN;
      end
      S_HRD: begin
        if (hidx_w >= log_used || LC'(hidx) != LC'(5'(hidx)) ||
            (LC < 5 && hidx >= 5'(log_used))) begin
          st_next = ST_BAD_IDX; done_set = 1'b1; state_next = S_IDLE;
        end else begin
          lg_rd_en = 1'b1; log_raddr = hslot; state_next = S_HOUT;
        end
      end
      S_HOUT: begin
        done_set = 1'b1; state_next = S_IDLE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers and counters
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key <= in_ch.sensor_key;
      temp <= in_ch.temperature; ts <= in_ch.timestamp;
      hidx <= in_ch.history_index;
      tcnt <= '0; lcnt <= '0; tfound <= 1'b0;
    end
    if (state == S_TSCAN && !tfound && tcnt >= trk_used)
      trk_cur <= {key, PH_NORMAL, KIND_NONE, 8'd0, 32'd0};
    if (state == S_TSCAN && !(tfound || tcnt >= trk_used)) tslot <= TW'(tcnt);
    if (state == S_TSCAN && !tfound && tcnt >= trk_used) tslot <= TW'(trk_used);
    if (state == S_TRD) begin
      tcnt <= tcnt + 1'b1;
      if (t_key == key) begin
        tfound <= 1'b1; trk_cur <= trk_rd;
      end
    end
    if ((state == S_LSCAN || state == S_RSCAN) && lcnt < log_used) lslot <= LW'(lcnt);
    if (state == S_LRD || state == S_RRD) lcnt <= lcnt + 1'b1;
  end

  // allocation and ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      trk_used <= '0; log_used <= '0; log_oldest <= '0;
    end else begin
      if (state == S_TUPD && !tfound) trk_used <= trk_used + 1'b1;
      if (state == S_LADD) begin
        if (log_used < LC'(HISTORY_DEPTH)) log_used <= log_used + 1'b1;
        else log_oldest <= (log_oldest == LW'(HISTORY_DEPTH - 1)) ? '0 : log_oldest + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done_set) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (done_set) begin
      o_status <= st_next;
      o_rec <= (state == S_HOUT) ? log_rd : '0;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.status          = o_status;
  assign out_ch.rec_sensor_key  = o_rec[LRW-1 -: 16];
  assign out_ch.rec_kind        = o_rec[82:81];
  assign out_ch.rec_temperature = o_rec[80:65];
  assign out_ch.rec_start_time  = o_rec[64:33];
  assign out_ch.rec_end_time    = o_rec[32:1];
  assign out_ch.rec_active      = o_rec[0];
  assign out_ch.history_fill    = 6'(log_used);

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    log_used <= LC'(HISTORY_DEPTH)) else $error("log fill overflow");
  a_trk_bound: assert property (@(posedge clk) disable iff (rst)
    trk_used <= TC'(SENSOR_SLOTS)) else $error("tracker count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ch.ready) else $error("accept while result pending");
  a_oldest_still: assert property (@(posedge clk) disable iff (rst)
    (log_used < LC'(HISTORY_DEPTH)) |-> log_oldest == '0)
    else $error("ring pointer moved before full");
endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for sensor_alarm_qualifier_log: directed and random alarm traffic,
// checked against an in-bench predictor of trackers and history ring.
// Depends on saq_pkg, the channel interfaces in saq_if.sv and the top level.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import saq_pkg::*;

  localparam int TRACKERS = SENSOR_SLOTS_DEF;
  localparam int RING     = HISTORY_DEPTH_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] key;
    logic [1:0]  kind;
    logic [15:0] temp;
    logic [31:0] start_t;
    logic [31:0] end_t;
    logic        active;
    logic [5:0]  fill;
  } alarm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  saq_in_if  in_ch();
  saq_out_if out_ch();
  saq_cfg_if cfg();

  sensor_alarm_qualifier_log u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  always #1 clk = ~clk;

  // Predictor state: configuration, tracker table and history ring
  logic signed [15:0] high_thr, low_thr;
  logic [7:0]  run_thr;
  logic [15:0] trk_key_m [TRACKERS];
  logic [1:0]  trk_phase_m [TRACKERS];
  logic [1:0]  trk_kind_m [TRACKERS];
  logic [7:0]  trk_run_m [TRACKERS];
  logic [31:0] trk_first_m [TRACKERS];
  int          trk_count;
  logic [15:0] ring_key [RING];
  logic [1:0]  ring_kind [RING];
  logic [15:0] ring_temp [RING];
  logic [31:0] ring_start [RING];
  logic [31:0] ring_end [RING];
  logic        ring_active [RING];
  int          ring_fill;
  int          ring_oldest;

  alarm_result_t pending_results[$];
  int err_count = 0;
  bit no_idle = 1'b0;
  logic [15:0] key_pool [TRACKERS];

  // Append an active alarm record unless the sensor already has one
  function automatic bit ring_append(logic [15:0] key, logic [1:0] kind,
                                     logic [15:0] temp, logic [31:0] start_t);
    int slot;
    for (int i = 0; i < ring_fill; i++)
      if (ring_active[i] && ring_key[i] == key) return 1'b0;
    if (ring_fill < RING) begin
      slot = ring_fill;
      ring_fill++;
    end else begin
      slot = ring_oldest;
      ring_oldest = (slot + 1) % RING;
    end
    ring_key[slot] = key;
    ring_kind[slot] = kind;
    ring_temp[slot] = temp;
    ring_start[slot] = start_t;
    ring_end[slot] = '0;
    ring_active[slot] = 1'b1;
    return 1'b1;
  endfunction

  // Qualify one reading against its sensor's tracker
  function automatic logic [2:0] qualify_reading(logic [15:0] key,
      logic signed [15:0] temp, logic [31:0] ts);
    int t;
    bit found;
    logic [1:0] kind;
    logic [2:0] st;
    found = 1'b0;
    st = ST_NONE;
    t = 0;
    for (int i = 0; i < trk_count; i++)
      if (!found && trk_key_m[i] == key) begin
        found = 1'b1;
        t = i;
      end
    if (!found) begin
      if (trk_count >= TRACKERS) return ST_FULL;
      t = trk_count;
      trk_count++;
      trk_key_m[t] = key;
      trk_phase_m[t] = PH_NORMAL;
      trk_kind_m[t] = KIND_NONE;
      trk_run_m[t] = '0;
      trk_first_m[t] = '0;
    end
    if (temp > high_thr) kind = KIND_HIGH;
    else if (temp < low_thr) kind = KIND_LOW;
    else kind = KIND_NONE;

    if (kind != KIND_NONE) begin
      if (trk_phase_m[t] == PH_NORMAL) begin
        trk_phase_m[t] = PH_PENDING;
        trk_kind_m[t] = kind;
        trk_run_m[t] = 8'd1;
        trk_first_m[t] = ts;
      end else if (trk_phase_m[t] == PH_PENDING) begin
        if (trk_kind_m[t] == kind) begin
          if (trk_run_m[t] != 8'd255) trk_run_m[t]++;
          if (trk_run_m[t] >= run_thr) begin
            trk_phase_m[t] = PH_TRIGGERED;
            if (ring_append(key, kind, temp, trk_first_m[t])) st = ST_RAISED;
          end
        end else begin
          trk_kind_m[t] = kind;
          trk_run_m[t] = 8'd1;
          trk_first_m[t] = ts;
        end
      end
    end else begin
      if (trk_phase_m[t] == PH_TRIGGERED) begin
        for (int i = 0; i < ring_fill; i++)
          if (ring_active[i] && ring_key[i] == key) begin
            ring_active[i] = 1'b0;
            ring_end[i] = ts;
          end
        st = ST_CLEARED;
      end
      trk_phase_m[t] = PH_NORMAL;
      trk_run_m[t] = '0;
      trk_kind_m[t] = KIND_NONE;
    end
    return st;
  endfunction

  // Compute the expected result of one transaction and advance the state
  function automatic alarm_result_t predict_alarm(logic cmd, logic [15:0] key,
      logic is_temp, logic [15:0] temp, logic [31:0] ts, logic [4:0] hidx);
    alarm_result_t r;
    int slot;
    r = '0;
    if (cmd == CMD_CHECK) begin
      if (is_temp) r.status = qualify_reading(key, temp, ts);
    end else if (hidx >= ring_fill) begin
      r.status = ST_BAD_IDX;
    end else begin
      slot = (ring_fill >= RING) ? (ring_oldest + hidx) % RING : hidx;
      r.key = ring_key[slot];
      r.kind = ring_kind[slot];
      r.temp = ring_temp[slot];
      r.start_t = ring_start[slot];
      r.end_t = ring_end[slot];
      r.active = ring_active[slot];
    end
    r.fill = ring_fill[5:0];
    return r;
  endfunction

  // Send one item; valid stays high for a following back-to-back transaction
  task automatic send_item(logic cmd, logic [15:0] key, logic is_temp,
                           logic [15:0] temp, logic [31:0] ts, logic [4:0] hidx);
    while (!no_idle && $urandom_range(0, 99) < 8) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = cmd;
    in_ch.sensor_key = key;
    in_ch.is_temperature = is_temp;
    in_ch.temperature = temp;
    in_ch.timestamp = ts;
    in_ch.history_index = hidx;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_alarm(cmd, key, is_temp, temp, ts, hidx));
    @(negedge clk);
  endtask

  task automatic check_temp(logic [15:0] key, logic [15:0] temp);
    send_item(CMD_CHECK, key, 1'b1, temp, $urandom, 5'($urandom));
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    drain_results();
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = value;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_HIGH: high_thr = value;
      REG_LOW:  low_thr = value;
      default:  run_thr = value[7:0];
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic set_thresholds(int hi, int lo, int run);
    write_reg(REG_HIGH, 16'(hi));
    write_reg(REG_LOW, 16'(lo));
    write_reg(REG_RUN, 16'(run));
  endtask

  // Temperature of a requested class; falls back to normal when none exists
  function automatic logic [15:0] pick_temp(logic [1:0] kind);
    int hi, lo;
    hi = high_thr;
    lo = low_thr;
    if (kind == KIND_HIGH && hi < 32767)
      return 16'(hi + 1 + $urandom_range(0, 32766 - hi));
    if (kind == KIND_LOW && lo > -32768)
      return 16'(-32768 + $urandom_range(0, lo + 32767));
    return 16'(lo + $urandom_range(0, hi - lo));
  endfunction

  // Reset defaults: bad index, ignored reading, run restart, trigger, clear
  task automatic test_directed();
    send_item(CMD_READ, 16'hFFFF, 1'b1, 16'h7FFF, 32'hFFFF_FFFF, 5'd0);
    send_item(CMD_CHECK, 16'h0000, 1'b0, 16'h7FFF, 32'd0, 5'd31);
    send_item(CMD_CHECK, 16'h0000, 1'b1, 16'h7FFF, 32'd0, 5'd0);
    send_item(CMD_CHECK, 16'h0000, 1'b1, 16'd481, 32'd10, 5'd0);
    send_item(CMD_CHECK, 16'h0000, 1'b1, 16'h8000, 32'hFFFF_FFFF, 5'd0);
    send_item(CMD_CHECK, 16'h0000, 1'b1, 16'hFFFF, 32'd20, 5'd0);
    send_item(CMD_CHECK, 16'h0000, 1'b1, 16'hFFF0, 32'd30, 5'd0);
    send_item(CMD_CHECK, 16'h0000, 1'b1, 16'h7FFF, 32'd40, 5'd0);
    send_item(CMD_CHECK, 16'h0000, 1'b1, 16'd0, 32'h8000_0000, 5'd0);
    send_item(CMD_READ, 16'h0000, 1'b0, 16'd0, 32'd0, 5'd0);
    send_item(CMD_READ, 16'h0000, 1'b0, 16'd0, 32'd0, 5'd1);
    send_item(CMD_CHECK, 16'hFFFF, 1'b1, 16'd480, 32'd50, 5'd0);
    // fill the tracker table, then hit it with an unknown sensor
    for (int i = 2; i < TRACKERS; i++) check_temp(key_pool[i], 16'd100);
    check_temp(16'h5A5A, 16'd100);
  endtask

  // Well-formed alarm runs with noise, reads and unknown sensors mixed in
  task automatic test_random_traffic(int items);
    int sent, len, sel;
    logic [1:0] kind;
    logic [15:0] key;
    sent = 0;
    while (sent < items) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        send_item(CMD_READ, 16'($urandom), 1'($urandom), 16'($urandom), $urandom,
                  5'($urandom_range(0, 31)));
        sent++;
      end else if (sel < 17) begin
        send_item(CMD_CHECK, 16'($urandom), 1'b0, 16'($urandom), $urandom, 5'($urandom));
        sent++;
      end else if (sel < 22) begin
        check_temp(16'($urandom), 16'($urandom));
        sent++;
      end else begin
        key = key_pool[$urandom_range(0, TRACKERS - 1)];
        kind = $urandom_range(0, 1) ? KIND_HIGH : KIND_LOW;
        len = $urandom_range(1, (run_thr > 6) ? 8 : run_thr + 2);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) kind = (kind == KIND_HIGH) ? KIND_LOW : KIND_HIGH;
          check_temp(key, pick_temp(kind));
          sent++;
        end
        if ($urandom_range(0, 9) < 8) begin
          check_temp(key, pick_temp(KIND_NONE));
          sent++;
        end
      end
    end
  endtask

  // Hold the sender until every expected result has arrived, then send more traffic
  task automatic test_sender_hold();
    drain_results();
    test_random_traffic(40);
  endtask

  // Result channel backpressure
  always @(negedge clk)
    out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 8);

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    alarm_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result, status %0d", out_ch.status);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_ch.status); err_count++;
        end
        if (out_ch.rec_sensor_key !== exp_r.key) begin
          $error("rec_sensor_key exp %h got %h", exp_r.key, out_ch.rec_sensor_key);
          err_count++;
        end
        if (out_ch.rec_kind !== exp_r.kind) begin
          $error("rec_kind exp %0d got %0d", exp_r.kind, out_ch.rec_kind); err_count++;
        end
        if (out_ch.rec_temperature !== exp_r.temp) begin
          $error("rec_temperature exp %h got %h", exp_r.temp, out_ch.rec_temperature);
          err_count++;
        end
        if (out_ch.rec_start_time !== exp_r.start_t) begin
          $error("rec_start_time exp %h got %h", exp_r.start_t, out_ch.rec_start_time);
          err_count++;
        end
        if (out_ch.rec_end_time !== exp_r.end_t) begin
          $error("rec_end_time exp %h got %h", exp_r.end_t, out_ch.rec_end_time);
          err_count++;
        end
        if (out_ch.rec_active !== exp_r.active) begin
          $error("rec_active exp %0d got %0d", exp_r.active, out_ch.rec_active);
          err_count++;
        end
        if (out_ch.history_fill !== exp_r.fill) begin
          $error("history_fill exp %0d got %0d", exp_r.fill, out_ch.history_fill);
          err_count++;
        end
      end
    end
  end

  initial begin
    bit dup;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CHECK;
    in_ch.sensor_key = '0;
    in_ch.is_temperature = 1'b0;
    in_ch.temperature = '0;
    in_ch.timestamp = '0;
    in_ch.history_index = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_HIGH;
    cfg.data = '0;
    out_ch.ready = 1'b0;
    high_thr = 16'sd480;
    low_thr = 16'sd0;
    run_thr = 8'd3;
    trk_count = 0;
    ring_fill = 0;
    ring_oldest = 0;
    // distinct sensor keys, with the all-zero and all-one keys first
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < TRACKERS; i++) begin
      do begin
        key_pool[i] = 16'($urandom);
        dup = (key_pool[i] == 16'h5A5A);
        for (int j = 0; j < i; j++) if (key_pool[j] == key_pool[i]) dup = 1'b1;
      end while (dup);
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_traffic(300);
    test_sender_hold();
    set_thresholds(100, -100, 1);
    no_idle = 1'b1;
    test_random_traffic(150);
    no_idle = 1'b0;
    test_random_traffic(150);
    set_thresholds(32767, -32768, 255);
    test_random_traffic(80);
    set_thresholds(-32768, -32768, 2);
    test_random_traffic(80);
    set_thresholds(2000, -500, 5);
    test_random_traffic(100);

    drain_results();
    repeat (80) @(negedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: errors");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
src/saq_pkg.sv
src/saq_if.sv
src/sensor_alarm_qualifier_log.sv
tb/tb.sv
